// ===== hdl/focus_stack_peak_depth_top_assert.svh =====
// Assertion macros shared by the focus stack blocks
`ifndef FOCUS_STACK_PEAK_DEPTH_TOP_ASSERT_SVH
`define FOCUS_STACK_PEAK_DEPTH_TOP_ASSERT_SVH

// Check that a condition implies a consequence in the same cycle
`define FSPD_ASSERT_IMPLY(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error(msg);

// Check that a condition implies a consequence in the following cycle
`define FSPD_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/fspd_pkg.sv =====
package fspd_pkg;

   localparam int MAX_PIXELS_DEF    = 65536;
   localparam int MAX_FRAMES_DEF    = 256;
   localparam int FRACTION_BITS_DEF = 8;

   localparam int PIX_W   = 16;
   localparam int FRAME_W = 8;
   localparam int SHARP_W = 32;
   localparam int DEPTH_W = 16;
   localparam int COUNT_W = 9;

   // one stored entry per pixel
   localparam int ENTRY_W = 3 * SHARP_W + FRAME_W + SHARP_W;

   typedef struct packed {
      logic [PIX_W-1:0]   pixel_index;
      logic [FRAME_W-1:0] frame_number;
      logic [SHARP_W-1:0] sharpness;
   } req_type;

   typedef struct packed {
      logic [PIX_W-1:0]   pixel_out;
      logic [DEPTH_W-1:0] depth;
      logic [SHARP_W-1:0] peak_sharpness;
   } rsp_type;

   typedef struct packed {
      logic [SHARP_W-1:0] best_value;
      logic [FRAME_W-1:0] best_frame;
      logic [SHARP_W-1:0] before_best;
      logic [SHARP_W-1:0] after_best;
      logic [SHARP_W-1:0] previous_value;
   } entry_type;

   // job handed from the update stage to the offset divider
   typedef struct packed {
      logic [PIX_W-1:0]   pixel;
      logic [FRAME_W-1:0] best_frame;
      logic [SHARP_W-1:0] best_value;
      logic               refine;
      logic [SHARP_W-1:0] prev;
      logic [SHARP_W-1:0] next;
   } job_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_UPDATE,
      ST_WAIT
   } state_type;

endpackage

// ===== hdl/fspd_ram.sv =====
module fspd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/fspd_offset.sv =====
`include "focus_stack_peak_depth_top_assert.svh"

module fspd_offset #(
   parameter int FRACTION_BITS = fspd_pkg::FRACTION_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   output logic              job_ready,
   input  fspd_pkg::job_type job,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output fspd_pkg::rsp_type rsp
);

   localparam int SW  = fspd_pkg::SHARP_W;
   localparam int NW  = SW + 1;
   localparam int DW  = SW + 3;
   localparam int QW  = FRACTION_BITS + 2;
   localparam int CW  = $clog2(QW + 1);
   localparam int ONE = 1 << FRACTION_BITS;
   localparam int EW  = fspd_pkg::FRAME_W + FRACTION_BITS + 1;

   logic              busy_ff, busy_in;
   logic              out_valid_ff, out_valid_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [DW-1:0]     rem_ff, rem_in;
   logic [DW-1:0]     den_ff, den_in;
   logic [QW-1:0]     quo_ff, quo_in;
   logic              neg_ff, neg_in;
   logic              refine_ff, refine_in;
   logic [fspd_pkg::PIX_W-1:0]   pix_ff;
   logic [fspd_pkg::FRAME_W-1:0] frame_ff;
   logic [SW-1:0]                 best_ff;
   fspd_pkg::rsp_type rsp_ff, rsp_in;

   logic signed [NW:0] num_s;
   logic signed [DW:0] den_s;
   logic [DW-1:0]      trial;
   logic [QW-1:0]      qclamp;
   logic signed [EW:0] depth_s;
   logic               done;

   // form numerator and denominator of the parabola vertex
   always_comb begin
      num_s = $signed({2'b00, job.prev}) - $signed({2'b00, job.next});
      den_s = ($signed({4'b0000, job.prev}) + $signed({4'b0000, job.next})
               - $signed({3'b000, job.best_value, 1'b0})) <<< 1;
   end

   assign done = busy_ff && (cnt_ff == CW'(0));
   assign job_ready = !busy_ff && (!out_valid_ff || rsp_ready);

   // restoring division, one quotient bit a cycle
   always_comb begin
      busy_in      = busy_ff;
      cnt_in       = cnt_ff;
      rem_in       = rem_ff;
      den_in       = den_ff;
      quo_in       = quo_ff;
      neg_in       = neg_ff;
      refine_in    = refine_ff;
      out_valid_in = out_valid_ff;
      rsp_in       = rsp_ff;
      trial        = '0;
      qclamp       = (quo_ff > QW'(ONE)) ? QW'(ONE) : quo_ff;
      depth_s      = $signed({1'b0, EW'(frame_ff) << FRACTION_BITS});
      if (refine_ff) begin
         depth_s = neg_ff ? depth_s - $signed({1'b0, EW'(qclamp)})
                          : depth_s + $signed({1'b0, EW'(qclamp)});
      end
      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (job_valid && job_ready) begin
         busy_in   = 1'b1;
         refine_in = job.refine;
         neg_in    = (num_s < 0) != (den_s < 0);
         rem_in    = DW'(num_s < 0 ? -num_s : num_s);
         den_in    = DW'(den_s < 0 ? -den_s : den_s);
         quo_in    = '0;
         cnt_in    = CW'(QW);
         if (den_s == 0) begin
            // flat parabola: step a whole frame by the numerator's sign
            cnt_in    = '0;
            quo_in    = (num_s == 0) ? '0 : QW'(ONE);
            neg_in    = num_s < 0;
         end
      end else if (busy_ff && !done) begin
         // bring down bit of the scaled numerator
         trial = {rem_ff[DW-2:0], 1'b0};
         if (cnt_ff > CW'(FRACTION_BITS)) begin
            trial = rem_ff;
         end
         rem_in = (trial >= den_ff) ? trial - den_ff : trial;
         quo_in = {quo_ff[QW-2:0], trial >= den_ff};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff > CW'(FRACTION_BITS) && cnt_ff != CW'(FRACTION_BITS + 1)) begin
            quo_in = '0;
            rem_in = rem_ff;
            if (rem_ff >= den_ff) begin
               // quotient will clamp at one in any case
               quo_in = QW'(ONE + 1);
               cnt_in = '0;
            end
         end else if (cnt_ff == CW'(FRACTION_BITS + 1)) begin
            quo_in = {{(QW-1){1'b0}}, trial >= den_ff};
         end
      end else if (done) begin
         // hold the result in the output register
         busy_in          = 1'b0;
         out_valid_in     = 1'b1;
         rsp_in.pixel_out = pix_ff;
         rsp_in.peak_sharpness = best_ff;
         rsp_in.depth     = (depth_s < 0) ? '0 : fspd_pkg::DEPTH_W'(depth_s);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
      cnt_ff    <= cnt_in;
      rem_ff    <= rem_in;
      den_ff    <= den_in;
      quo_ff    <= quo_in;
      neg_ff    <= neg_in;
      refine_ff <= refine_in;
      rsp_ff    <= rsp_in;
      if (job_valid && job_ready) begin
         pix_ff   <= job.pixel;
         frame_ff <= job.best_frame;
         best_ff  <= job.best_value;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp       = rsp_ff;

   `FSPD_ASSERT_IMPLY(a_no_job_busy, clock, reset, busy_ff, !job_ready, "job taken while busy")
   `FSPD_ASSERT_NEXT(a_done_out, clock, reset, done, out_valid_ff, "result not presented")
   `FSPD_ASSERT_NEXT(a_hold_out, clock, reset, out_valid_ff && !rsp_ready,
      out_valid_ff && $stable(rsp_ff), "stalled result changed")

endmodule

// ===== hdl/focus_stack_peak_depth_top.sv =====
// Focus stack depth: per pixel peak search with parabolic sub-frame refinement.
// Input channel req_*: one beat carries a pixel, a frame number and its sharpness.
// Frames of a pixel must arrive in order from 0; frame 0 restarts the pixel.
// Result channel rsp_*: one beat per pixel on frame n-1, n being frame_count
// clamped to 1..MAX_FRAMES, with depth (8 fraction bits) and peak sharpness;
// other frames give no result. Configuration: csr_wr_en/csr_wr_data write
// frame_count; the user must write it only while idle, which the block does
// not enforce. Per pixel state lives in one synchronous RAM, read then written
// back. An item passes the accept, RAM read and update with write back states
// before the next is taken; the single RAM port pair sets this. A final frame
// then goes to the offset divider, whose steps end early when the offset clamps
// at one frame or the parabola is flat. Other items are taken meanwhile.
// Reset (synchronous) clears control only; RAM contents stay undefined and
// frame_count returns to 1. No clearing pass runs.
// When the receiver stalls, the result is held in the output register; a
// further final frame then waits after its update and holds the input off.
`include "focus_stack_peak_depth_top_assert.svh"

module focus_stack_peak_depth_top #(
   parameter int MAX_PIXELS    = fspd_pkg::MAX_PIXELS_DEF,
   parameter int MAX_FRAMES    = fspd_pkg::MAX_FRAMES_DEF,
   parameter int FRACTION_BITS = fspd_pkg::FRACTION_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  fspd_pkg::req_type             req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output fspd_pkg::rsp_type             rsp_data,
   input  logic                          csr_wr_en,
   input  logic [fspd_pkg::COUNT_W-1:0]  csr_wr_data
);

   localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
   localparam int FW = fspd_pkg::FRAME_W;

   fspd_pkg::state_type state_ff, state_in;
   logic [fspd_pkg::COUNT_W-1:0] count_ff;
   fspd_pkg::req_type req_ff;
   fspd_pkg::entry_type rd_entry, wr_entry;
   fspd_pkg::job_type job;
   logic job_valid, job_ready, wr_en, is_last;
   logic [fspd_pkg::COUNT_W-1:0] n_eff;
   logic [AW-1:0] addr;
   logic [FW-1:0] fr;

   assign addr = AW'(req_ff.pixel_index % MAX_PIXELS);
   assign fr   = req_ff.frame_number;

   // clamp frame count into its legal range
   always_comb begin
      n_eff = count_ff;
      if (count_ff == '0) n_eff = fspd_pkg::COUNT_W'(1);
      if (count_ff > fspd_pkg::COUNT_W'(MAX_FRAMES)) n_eff = fspd_pkg::COUNT_W'(MAX_FRAMES);
   end

   assign is_last = {1'b0, fr} == n_eff - fspd_pkg::COUNT_W'(1);

   // update the pixel entry
   always_comb begin
      wr_entry = rd_entry;
      if (fr == '0) begin
         wr_entry.best_value  = req_ff.sharpness;
         wr_entry.best_frame  = '0;
         wr_entry.before_best = '0;
         wr_entry.after_best  = '0;
      end else begin
         if (rd_entry.best_frame == fr - FW'(1)) wr_entry.after_best = req_ff.sharpness;
         if (req_ff.sharpness > rd_entry.best_value) begin
            wr_entry.before_best = rd_entry.previous_value;
            wr_entry.best_frame  = fr;
            wr_entry.best_value  = req_ff.sharpness;
            wr_entry.after_best  = '0;
         end
      end
      wr_entry.previous_value = req_ff.sharpness;
   end

   // build the divider job
   always_comb begin
      job.pixel      = req_ff.pixel_index;
      job.best_frame = wr_entry.best_frame;
      job.best_value = wr_entry.best_value;
      job.prev       = wr_entry.before_best;
      job.next       = wr_entry.after_best;
      job.refine     = (n_eff >= fspd_pkg::COUNT_W'(3)) && (wr_entry.best_frame != '0)
                       && ({1'b0, wr_entry.best_frame} < n_eff - fspd_pkg::COUNT_W'(1));
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fspd_pkg::ST_IDLE:   if (req_valid) state_in = fspd_pkg::ST_READ;
         fspd_pkg::ST_READ:   state_in = fspd_pkg::ST_UPDATE;
         fspd_pkg::ST_UPDATE: state_in = (is_last && !job_ready) ? fspd_pkg::ST_WAIT
                                                                : fspd_pkg::ST_IDLE;
         fspd_pkg::ST_WAIT:   if (job_ready) state_in = fspd_pkg::ST_IDLE;
         default:             state_in = fspd_pkg::ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_ready = 1'b0;
      wr_en     = 1'b0;
      job_valid = 1'b0;
      unique case (state_ff)
         fspd_pkg::ST_IDLE:   req_ready = 1'b1;
         fspd_pkg::ST_READ:   ;
         fspd_pkg::ST_UPDATE: begin
            wr_en     = 1'b1;
            job_valid = is_last;
         end
         fspd_pkg::ST_WAIT:   job_valid = 1'b1;
         default:             ;
      endcase
   end

   logic [$bits(fspd_pkg::job_type)-1:0] job_ff;
   fspd_pkg::job_type job_sel;
   assign job_sel = (state_ff == fspd_pkg::ST_WAIT) ? fspd_pkg::job_type'(job_ff) : job;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fspd_pkg::ST_IDLE;
         count_ff <= fspd_pkg::COUNT_W'(1);
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) count_ff <= csr_wr_data;
      end
      if (req_valid && req_ready) req_ff <= req_data;
      if (state_ff == fspd_pkg::ST_UPDATE) job_ff <= job;
   end

   // read the held beat's entry during the read cycle
   fspd_ram #(
      .WIDTH (fspd_pkg::ENTRY_W),
      .DEPTH (MAX_PIXELS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (addr),
      .wr_data (wr_entry),
      .rd_addr (addr),
      .rd_data (rd_entry)
   );

   fspd_offset #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_offset (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job_ready (job_ready),
      .job       (job_sel),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp_data)
   );

   `FSPD_ASSERT_IMPLY(a_ready_idle, clock, reset, req_ready, state_ff == fspd_pkg::ST_IDLE,
      "ready outside idle")
   `FSPD_ASSERT_NEXT(a_read_follows, clock, reset, req_valid && req_ready,
      state_ff == fspd_pkg::ST_READ, "accepted beat not read")
   `FSPD_ASSERT_IMPLY(a_write_once, clock, reset, wr_en, state_ff == fspd_pkg::ST_UPDATE,
      "write outside update")

endmodule

// ===== tb/sv/focus_stack_peak_depth_top_test.sv =====
`timescale 1ns / 100ps

module focus_stack_peak_depth_top_test;

   localparam int  FRAC       = fspd_pkg::FRACTION_BITS_DEF;
   localparam int  SETTLE     = fspd_pkg::FRACTION_BITS_DEF + 20;
   localparam int  CYCLE_CAP  = 500000;
   localparam int  MAXF       = fspd_pkg::MAX_FRAMES_DEF;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   fspd_pkg::req_type req_data = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   fspd_pkg::rsp_type rsp_data;
   logic            csr_wr_en = 1'b0;
   logic [fspd_pkg::COUNT_W-1:0] csr_wr_data = '0;

   focus_stack_peak_depth_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   // per pixel copy of the peak tracking state
   logic [fspd_pkg::SHARP_W-1:0] pk_best [int];
   logic [fspd_pkg::FRAME_W-1:0] pk_frame [int];
   logic [fspd_pkg::SHARP_W-1:0] pk_before [int];
   logic [fspd_pkg::SHARP_W-1:0] pk_after [int];
   logic [fspd_pkg::SHARP_W-1:0] pk_last [int];
   logic [fspd_pkg::COUNT_W-1:0] stack_frames = fspd_pkg::COUNT_W'(1);

   fspd_pkg::rsp_type depth_queue[$];
   int      beats_sent = 0;
   int      depths_seen = 0;
   int      mismatches = 0;
   int      cycles = 0;
   int      burst_left = 0;
   int      stall_mode = 0;

   // parabolic offset in fraction units, within plus or minus one frame
   function automatic longint sub_frame(longint prev, longint best, longint next);
      longint one;
      longint num;
      longint den;
      longint q;
      one = longint'(1) << FRAC;
      num = prev - next;
      den = 2 * (prev - 2 * best + next);
      if (den == 0) begin
         if (num == 0) return 0;
         return (num > 0) ? one : -one;
      end
      q = ((num < 0 ? -num : num) << FRAC) / (den < 0 ? -den : den);
      if (q > one) q = one;
      return ((num < 0) != (den < 0)) ? -q : q;
   endfunction

   // advance the pixel state by one beat; queue a depth on the last frame
   task automatic track_peak(fspd_pkg::req_type r);
      int      p;
      int      n;
      longint  d;
      fspd_pkg::rsp_type res;
      p = int'(r.pixel_index);
      n = (stack_frames == 0) ? 1 : (stack_frames > MAXF ? MAXF : int'(stack_frames));
      if (r.frame_number == 0) begin
         pk_best[p] = r.sharpness;
         pk_frame[p] = '0;
         pk_before[p] = '0;
         pk_after[p] = '0;
      end else begin
         if (pk_frame[p] == r.frame_number - 8'd1) pk_after[p] = r.sharpness;
         if (r.sharpness > pk_best[p]) begin
            pk_before[p] = pk_last[p];
            pk_frame[p] = r.frame_number;
            pk_best[p] = r.sharpness;
            pk_after[p] = '0;
         end
      end
      pk_last[p] = r.sharpness;
      if (int'(r.frame_number) != n - 1) return;
      d = longint'(pk_frame[p]) << FRAC;
      if (n >= 3 && pk_frame[p] > 0 && int'(pk_frame[p]) < n - 1)
         d += sub_frame(longint'(pk_before[p]), longint'(pk_best[p]),
                        longint'(pk_after[p]));
      if (d < 0) d = 0;
      res.pixel_out = r.pixel_index;
      res.depth = d[fspd_pkg::DEPTH_W-1:0];
      res.peak_sharpness = pk_best[p];
      depth_queue.push_back(res);
   endtask

   // send one beat, in bursts with random gaps
   task automatic send_sample(int pix, int frame, logic [fspd_pkg::SHARP_W-1:0] sharp);
      fspd_pkg::req_type r;
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(0, 6)) @(negedge clock);
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      r.pixel_index = fspd_pkg::PIX_W'(pix);
      r.frame_number = fspd_pkg::FRAME_W'(frame);
      r.sharpness = sharp;
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      track_peak(r);
      beats_sent++;
      @(negedge clock);
   endtask

   // hold until every queued depth has come back, then let the block settle
   task automatic drain();
      req_valid <= 1'b0;
      while (depth_queue.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic set_frames(int value);
      drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= fspd_pkg::COUNT_W'(value);
      @(negedge clock);
      csr_wr_en <= 1'b0;
      stack_frames = fspd_pkg::COUNT_W'(value);
   endtask

   // sharpness of frame f for a pixel of a given profile
   function automatic logic [fspd_pkg::SHARP_W-1:0] profile_value(int shape, int f,
                                                                 int peak, int scale);
      longint v;
      case (shape)
         0: return $urandom;
         1: return $urandom_range(0, 3);
         default: begin
            v = 64'hFFFF_0000 - longint'(scale) * (f - peak) * (f - peak)
                + $urandom_range(0, 255);
            if (v < 0) v = $urandom_range(0, 15);
            if (v > 64'hFFFF_FFFF) v = 64'hFFFF_FFFF;
            return v[31:0];
         end
      endcase
   endfunction

   // interleaved in-order streams for a few pixels, with some broken beats
   task automatic stream_pixels(int beats);
      int n;
      int pix[4];
      int next_f[4];
      int shape[4];
      int peak[4];
      int scale[4];
      int k;
      int noise_pix;
      n = (stack_frames == 0) ? 1 : (stack_frames > MAXF ? MAXF : int'(stack_frames));
      for (int i = 0; i < 4; i++) next_f[i] = -1;
      for (int b = 0; b < beats; b++) begin
         k = $urandom_range(0, 3);
         if (next_f[k] < 0 || next_f[k] >= n) begin
            pix[k] = $urandom_range(0, 65535);
            next_f[k] = 0;
            shape[k] = $urandom_range(0, 5);
            peak[k] = $urandom_range(0, n - 1);
            scale[k] = $urandom_range(1, 1 << $urandom_range(0, 28));
         end
         if ($urandom_range(0, 9) == 0 && pk_best.num() > 0) begin
            // drop a stray beat, on a pixel with state or else as frame 0 of a new one
            void'(pk_best.first(noise_pix));
            if ($urandom_range(0, 1)) noise_pix = pix[k];
            if (pk_best.exists(noise_pix))
               send_sample(noise_pix, $urandom_range(1, 255), $urandom);
            else
               send_sample(noise_pix, 0, $urandom);
         end else begin
            send_sample(pix[k], next_f[k],
                        profile_value(shape[k], next_f[k], peak[k], scale[k]));
            next_f[k]++;
         end
      end
   endtask

   task automatic test_single_frame();
      set_frames(1);
      send_sample(0, 0, 32'h0);
      send_sample(16'hFFFF, 0, 32'hFFFF_FFFF);
      send_sample(16'hA5A5, 0, 32'h5A5A_5A5A);
      stream_pixels(30);
   endtask

   task automatic test_two_frames();
      set_frames(2);
      send_sample(7, 0, 10);
      send_sample(7, 1, 20);
      send_sample(8, 0, 20);
      send_sample(8, 1, 20);
      stream_pixels(40);
   endtask

   task automatic test_parabola_edges();
      set_frames(3);
      // peak in the middle, balanced sides
      send_sample(1, 0, 100);
      send_sample(1, 1, 200);
      send_sample(1, 2, 100);
      // extreme sharpness values, giving offsets of nearly half a frame each way
      send_sample(2, 0, 32'hFFFF_FFFE);
      send_sample(2, 1, 32'hFFFF_FFFF);
      send_sample(2, 2, 0);
      send_sample(3, 0, 0);
      send_sample(3, 1, 32'hFFFF_FFFF);
      send_sample(3, 2, 32'hFFFF_FFFE);
      // ties keep the first frame
      send_sample(4, 0, 5);
      send_sample(4, 1, 5);
      send_sample(4, 2, 5);
      // winner on the last frame
      send_sample(5, 0, 1);
      send_sample(5, 1, 2);
      send_sample(5, 2, 3);
      // frames past the last and out of order
      send_sample(5, 7, 9);
      send_sample(5, 2, 0);
      stream_pixels(80);
   endtask

   task automatic test_mid_stack();
      set_frames(7);
      stream_pixels(50);
      // sender holds off until the block is empty
      drain();
      stream_pixels(50);
   endtask

   task automatic test_full_stack();
      set_frames(256);
      for (int f = 0; f < 256; f++)
         send_sample(16'h8001, f, profile_value(2, f, 131, 1000));
      stream_pixels(40);
   endtask

   task automatic test_count_clamp();
      set_frames(0);
      stream_pixels(30);
      set_frames(300);
      send_sample(16'h0F0F, 0, 3);
      send_sample(16'h0F0F, 255, 4);
      set_frames(511);
      stream_pixels(20);
   endtask

   // receiver stalls on its own pattern, changing mode now and then
   always @(negedge clock) begin
      if (($urandom_range(0, 63)) == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 3) != 0);
         2: rsp_ready <= ($urandom_range(0, 3) == 0);
         default: rsp_ready <= ~rsp_ready;
      endcase
   end

   // check each depth beat against the oldest prediction
   always @(posedge clock) begin
      fspd_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         depths_seen++;
         if (depth_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected depth beat: pixel %0d depth %0d peak %0d",
                        rsp_data.pixel_out, rsp_data.depth, rsp_data.peak_sharpness);
         end else begin
            want = depth_queue.pop_front();
            if (rsp_data.pixel_out !== want.pixel_out || rsp_data.depth !== want.depth
                || rsp_data.peak_sharpness !== want.peak_sharpness) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("depth mismatch: want pixel %0d depth %0d peak %0d, %s %0d %0d %0d",
                           want.pixel_out, want.depth, want.peak_sharpness, "got",
                           rsp_data.pixel_out, rsp_data.depth, rsp_data.peak_sharpness);
            end
         end
      end
   end

   // stop a hung run
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_CAP) begin
         $display("timeout after %0d cycles", cycles);
         $display("focus_stack_peak_depth_top verification failed");
         $finish;
      end
   end

   initial begin
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      test_single_frame();
      test_two_frames();
      test_parabola_edges();
      test_mid_stack();
      test_full_stack();
      test_count_clamp();
      drain();
      $display("sent %0d sharpness beats over stacks of 0 to 511 frames, checked %0d depths",
               beats_sent, depths_seen);
      $display("mismatches: %0d, depths still awaited: %0d", mismatches,
               depth_queue.size());
      if (mismatches == 0 && depth_queue.size() == 0)
         $display("focus_stack_peak_depth_top verification clean");
      else
         $display("focus_stack_peak_depth_top verification failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/fspd_pkg.sv
hdl/fspd_ram.sv
hdl/fspd_offset.sv
hdl/focus_stack_peak_depth_top.sv
tb/sv/focus_stack_peak_depth_top_test.sv
